// File: rtl/core/speck_pkg.sv
// Shared constants and types for the Speck block encryption core.
// No dependencies; used by speck_key_sched, speck_round and speck_block_encrypt.
package speck_pkg;

    localparam int WORD_BITS_DEF      = 32;
    localparam int KEY_WORD_COUNT_DEF = 4;
    localparam int ROUND_COUNT_DEF    = 27;
    localparam int ROT_RIGHT_DEF      = 8;
    localparam int ROT_LEFT_DEF       = 3;

    localparam int FIELD_BITS   = 32;
    localparam int REG_COUNT    = 4;
    localparam int REG_IDX_BITS = 2;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_KEY_WORD_0 = 2'd0,
        REG_KEY_WORD_1 = 2'd1,
        REG_KEY_WORD_2 = 2'd2,
        REG_KEY_WORD_3 = 2'd3
    } speck_reg_t;

    // key schedule status as seen by the datapath
    typedef struct packed {
        logic loading;
        logic expanding;
    } speck_ks_status_t;

endpackage

// File: rtl/core/speck_block_encrypt.sv
// Speck block encryption top level: key schedule, unrolled round pipeline, output skid.
// Depends on speck_pkg, speck_key_sched and speck_round.
//
// Speck64/128 encryption with one fully unrolled round per register stage. A plaintext
// word enters on in_valid when in_stall is low, one per cycle, and its ciphertext word
// leaves through the ROUND_COUNT round stages (27 with the defaults) and the output
// register. The rate is one word per clock as long as the output is taken and no key
// rebuild runs; the round stages move together on a common enable, and a two-entry
// output register/skid pair keeps the input open in the cycle the output stalls, so
// the upstream stall is a registered signal. Key words are written through the cfg
// port (index 0..3, always ready). After reset and after every key write the schedule
// is rebuilt one round key per cycle, and in_stall stays high during that time so no
// word is encrypted with a half-built schedule. Key writes are expected only while no
// word is in flight. Only the first KEY_WORD_COUNT key words take part; with WORD_BITS
// below 32 inputs and keys are truncated, above 32 the outputs carry the low 32 bits.
module speck_block_encrypt #(
    parameter int WORD_BITS      = speck_pkg::WORD_BITS_DEF,
    parameter int KEY_WORD_COUNT = speck_pkg::KEY_WORD_COUNT_DEF,
    parameter int ROUND_COUNT    = speck_pkg::ROUND_COUNT_DEF,
    parameter int ROT_RIGHT      = speck_pkg::ROT_RIGHT_DEF,
    parameter int ROT_LEFT       = speck_pkg::ROT_LEFT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [speck_pkg::REG_IDX_BITS-1:0]  cfg_index,
    input  logic [speck_pkg::FIELD_BITS-1:0]    cfg_data,
    // plaintext channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [speck_pkg::FIELD_BITS-1:0]    plain_left,
    input  logic [speck_pkg::FIELD_BITS-1:0]    plain_right,
    // ciphertext channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [speck_pkg::FIELD_BITS-1:0]    cipher_left,
    output logic [speck_pkg::FIELD_BITS-1:0]    cipher_right
);
    import speck_pkg::*;

    speck_ks_status_t      ks_status;
    logic [WORD_BITS-1:0]  round_keys [ROUND_COUNT];
    logic                  ks_busy;

    // stage 0 is the accepted word, stage ROUND_COUNT the last round's register
    logic                  st_valid [ROUND_COUNT+1];
    logic [WORD_BITS-1:0]  st_x     [ROUND_COUNT+1];
    logic [WORD_BITS-1:0]  st_y     [ROUND_COUNT+1];

    logic                  pipe_en;
    logic                  in_acc;
    logic                  arrive;
    logic                  out_ready;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  skid_valid_reg;
    logic                  skid_valid_next;
    logic [WORD_BITS-1:0]  out_x_reg;
    logic [WORD_BITS-1:0]  out_y_reg;
    logic [WORD_BITS-1:0]  skid_x_reg;
    logic [WORD_BITS-1:0]  skid_y_reg;

    speck_key_sched #(
        .WORD_BITS      (WORD_BITS),
        .KEY_WORD_COUNT (KEY_WORD_COUNT),
        .ROUND_COUNT    (ROUND_COUNT),
        .ROT_RIGHT      (ROT_RIGHT),
        .ROT_LEFT       (ROT_LEFT)
    ) u_key_sched (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .status     (ks_status),
        .round_keys (round_keys)
    );

    assign ks_busy = ks_status.loading || ks_status.expanding;

    // Rounds advance together whenever the skid entry is free; the skid absorbs the
    // one word that may still arrive in the cycle the output stalls.
    assign pipe_en  = !skid_valid_reg;
    assign in_stall = skid_valid_reg || ks_busy;
    assign in_acc   = in_valid && !in_stall;

    assign st_valid[0] = in_acc;
    assign st_x[0]     = WORD_BITS'(plain_left);
    assign st_y[0]     = WORD_BITS'(plain_right);

    for (genvar r = 0; r < ROUND_COUNT; r++)
    begin : g_round
        speck_round #(
            .WORD_BITS (WORD_BITS),
            .ROT_RIGHT (ROT_RIGHT),
            .ROT_LEFT  (ROT_LEFT)
        ) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (pipe_en),
            .in_valid  (st_valid[r]),
            .in_x      (st_x[r]),
            .in_y      (st_y[r]),
            .round_key (round_keys[r]),
            .out_valid (st_valid[r+1]),
            .out_x     (st_x[r+1]),
            .out_y     (st_y[r+1])
        );
    end

    // output register and skid entry
    assign arrive    = pipe_en && st_valid[ROUND_COUNT];
    assign out_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = arrive;
            end
        end
        else if (arrive)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_x_reg <= skid_x_reg;
                out_y_reg <= skid_y_reg;
            end
            else if (arrive)
            begin
                out_x_reg <= st_x[ROUND_COUNT];
                out_y_reg <= st_y[ROUND_COUNT];
            end
        end
        else if (arrive)
        begin
            skid_x_reg <= st_x[ROUND_COUNT];
            skid_y_reg <= st_y[ROUND_COUNT];
        end
    end

    assign out_valid    = out_valid_reg;
    assign cipher_left  = FIELD_BITS'(out_x_reg);
    assign cipher_right = FIELD_BITS'(out_y_reg);

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a word while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid filled without an output stall");

    a_no_accept_while_keying: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> !ks_busy)
        else $error("word accepted during key expansion");

    a_last_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (arrive && !out_ready) |=> skid_valid_reg)
        else $error("finished word lost at the output");
`endif

endmodule

// File: rtl/core/speck_key_sched.sv
// Key word registers and iterative Speck key expansion, one round key per cycle.
// Depends on speck_pkg.
module speck_key_sched #(
    parameter int WORD_BITS      = speck_pkg::WORD_BITS_DEF,
    parameter int KEY_WORD_COUNT = speck_pkg::KEY_WORD_COUNT_DEF,
    parameter int ROUND_COUNT    = speck_pkg::ROUND_COUNT_DEF,
    parameter int ROT_RIGHT      = speck_pkg::ROT_RIGHT_DEF,
    parameter int ROT_LEFT       = speck_pkg::ROT_LEFT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [speck_pkg::REG_IDX_BITS-1:0]   cfg_index,
    input  logic [speck_pkg::FIELD_BITS-1:0]     cfg_data,
    output speck_pkg::speck_ks_status_t          status,
    output logic [WORD_BITS-1:0]                 round_keys [ROUND_COUNT]
);
    import speck_pkg::*;

    localparam int SCHED_LEN = KEY_WORD_COUNT - 1;
    localparam int CNT_W     = $clog2(ROUND_COUNT);
    localparam int LAST_STEP = ROUND_COUNT - 2;

    logic [FIELD_BITS-1:0] key_reg [REG_COUNT];
    logic [WORD_BITS-1:0]  l_reg   [SCHED_LEN];
    logic [WORD_BITS-1:0]  k_reg;
    logic [WORD_BITS-1:0]  rk_reg  [ROUND_COUNT];
    logic [CNT_W-1:0]      cnt_reg;
    logic                  load_reg;
    logic                  load_next;
    logic                  run_reg;
    logic                  run_next;
    logic                  cfg_wr;

    logic [WORD_BITS-1:0]  l_ror;
    logic [WORD_BITS-1:0]  k_rol;
    logic [WORD_BITS-1:0]  nl;
    logic [WORD_BITS-1:0]  k_next;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // one schedule step
    assign l_ror  = {l_reg[0][ROT_RIGHT-1:0], l_reg[0][WORD_BITS-1:ROT_RIGHT]};
    assign k_rol  = {k_reg[WORD_BITS-ROT_LEFT-1:0], k_reg[WORD_BITS-1:WORD_BITS-ROT_LEFT]};
    assign nl     = (k_reg + l_ror) ^ WORD_BITS'(cnt_reg);
    assign k_next = k_rol ^ nl;

    always_comb
    begin
        load_next = 1'b0;
        run_next  = run_reg;
        if (cfg_wr)
        begin
            // a write restarts the expansion from the new key words
            load_next = 1'b1;
            run_next  = 1'b0;
        end
        else if (load_reg)
        begin
            run_next = 1'b1;
        end
        else if (run_reg && (cnt_reg == CNT_W'(LAST_STEP)))
        begin
            run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg <= 1'b1;
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            for (int j = 0; j < REG_COUNT; j++)
            begin
                key_reg[j] <= '0;
            end
        end
        else
        begin
            load_reg <= load_next;
            run_reg  <= run_next;
            if (load_reg)
            begin
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cfg_wr)
            begin
                unique case (speck_reg_t'(cfg_index))
                    REG_KEY_WORD_0: key_reg[0] <= cfg_data;
                    REG_KEY_WORD_1: key_reg[1] <= cfg_data;
                    REG_KEY_WORD_2: key_reg[2] <= cfg_data;
                    REG_KEY_WORD_3: key_reg[3] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_reg)
        begin
            k_reg     <= WORD_BITS'(key_reg[0]);
            rk_reg[0] <= WORD_BITS'(key_reg[0]);
            for (int j = 0; j < SCHED_LEN; j++)
            begin
                l_reg[j] <= WORD_BITS'(key_reg[j+1]);
            end
        end
        else if (run_reg)
        begin
            k_reg <= k_next;
            rk_reg[CNT_W'(cnt_reg + 1'b1)] <= k_next;
            for (int j = 0; j < SCHED_LEN - 1; j++)
            begin
                l_reg[j] <= l_reg[j+1];
            end
            l_reg[SCHED_LEN-1] <= nl;
        end
    end

    assign round_keys       = rk_reg;
    assign status.loading   = load_reg;
    assign status.expanding = run_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (cnt_reg <= CNT_W'(LAST_STEP)))
        else $error("key schedule step counter overran");

    a_wr_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (load_reg && !run_reg))
        else $error("key write did not restart the expansion");

    a_load_then_run: assert property (@(posedge clk) disable iff (!rst_n)
        (load_reg && !cfg_wr) |=> (run_reg && cnt_reg == '0))
        else $error("expansion did not start after loading");

    a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(load_reg && run_reg))
        else $error("load and expansion active together");
`endif

endmodule

// File: rtl/core/speck_round.sv
// One registered Speck ARX round stage with its valid bit.
// Depends on speck_pkg for parameter defaults.
module speck_round #(
    parameter int WORD_BITS = speck_pkg::WORD_BITS_DEF,
    parameter int ROT_RIGHT = speck_pkg::ROT_RIGHT_DEF,
    parameter int ROT_LEFT  = speck_pkg::ROT_LEFT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [WORD_BITS-1:0] in_x,
    input  logic [WORD_BITS-1:0] in_y,
    input  logic [WORD_BITS-1:0] round_key,
    output logic                 out_valid,
    output logic [WORD_BITS-1:0] out_x,
    output logic [WORD_BITS-1:0] out_y
);
    import speck_pkg::*;

    logic                 valid_reg;
    logic [WORD_BITS-1:0] x_reg;
    logic [WORD_BITS-1:0] y_reg;
    logic [WORD_BITS-1:0] x_ror;
    logic [WORD_BITS-1:0] y_rol;
    logic [WORD_BITS-1:0] x_next;
    logic [WORD_BITS-1:0] y_next;

    assign x_ror  = {in_x[ROT_RIGHT-1:0], in_x[WORD_BITS-1:ROT_RIGHT]};
    assign y_rol  = {in_y[WORD_BITS-ROT_LEFT-1:0], in_y[WORD_BITS-1:WORD_BITS-ROT_LEFT]};
    assign x_next = (x_ror + in_y) ^ round_key;
    assign y_next = y_rol ^ x_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;

endmodule

// File: tb/speck_block_encrypt_tb.sv
// Self-checking testbench for speck_block_encrypt: a directed table, then random plaintext
// under four idling patterns and a long output hold. Depends on speck_pkg and the RTL only.
module speck_block_encrypt_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import speck_pkg::*;

    // The instance uses the package defaults, so these mirror the block's build.
    localparam int WORD_BITS      = WORD_BITS_DEF;
    localparam int KEY_WORD_COUNT = KEY_WORD_COUNT_DEF;
    localparam int ROUND_COUNT    = ROUND_COUNT_DEF;
    localparam int ROT_RIGHT      = ROT_RIGHT_DEF;
    localparam int ROT_LEFT       = ROT_LEFT_DEF;

    localparam int CLK_PERIOD_NS  = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int PHASE_WORDS    = 120;
    localparam int LONG_HOLD      = 300;    // output hold-off, well past pipeline depth
    localparam int TAIL_CYCLES    = ROUND_COUNT + 8;
    // Longest honest quiet stretch is the long hold or a schedule rebuild; sender gaps
    // at 74 % idle are short. Several times over gives the limit.
    localparam int WATCHDOG_LIMIT = 4000;

    // Idling per random phase: none, sender only, receiver only, both lightly.
    localparam int unsigned SEND_IDLE  [4] = '{0, 74, 0, 9};
    localparam int unsigned RECV_STALL [4] = '{0, 0, 74, 9};

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        word_t left;
        word_t right;
    } block_t;

    typedef enum logic {ROW_PLAIN, ROW_KEY} row_kind_t;

    // One directed step: a key write (reg_idx, a) or a plaintext word (a, b). Where the
    // ciphertext is known outright it is typed in; otherwise the predictor supplies it.
    typedef struct packed {
        row_kind_t  kind;
        speck_reg_t reg_idx;
        word_t      a;
        word_t      b;
        logic       known;
        block_t     want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 22;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // all-zero key straight after reset; plaintext extremes
        '{ROW_PLAIN, REG_KEY_WORD_0, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{ROW_PLAIN, REG_KEY_WORD_0, 32'hffff_ffff, 32'hffff_ffff, 1'b0, '0},
        '{ROW_PLAIN, REG_KEY_WORD_0, 32'hffff_ffff, 32'h0000_0000, 1'b0, '0},
        '{ROW_PLAIN, REG_KEY_WORD_0, 32'h0000_0000, 32'hffff_ffff, 1'b0, '0},
        '{ROW_PLAIN, REG_KEY_WORD_0, 32'h8000_0000, 32'h0000_0001, 1'b0, '0},
        // all-ones key
        '{ROW_KEY,   REG_KEY_WORD_0, 32'hffff_ffff, 32'h0000_0000, 1'b0, '0},
        '{ROW_KEY,   REG_KEY_WORD_1, 32'hffff_ffff, 32'h0000_0000, 1'b0, '0},
        '{ROW_KEY,   REG_KEY_WORD_2, 32'hffff_ffff, 32'h0000_0000, 1'b0, '0},
        '{ROW_KEY,   REG_KEY_WORD_3, 32'hffff_ffff, 32'h0000_0000, 1'b0, '0},
        '{ROW_PLAIN, REG_KEY_WORD_0, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{ROW_PLAIN, REG_KEY_WORD_0, 32'hffff_ffff, 32'hffff_ffff, 1'b0, '0},
        '{ROW_PLAIN, REG_KEY_WORD_0, 32'h5555_5555, 32'haaaa_aaaa, 1'b0, '0},
        // published Speck64/128 known-answer vector
        '{ROW_KEY,   REG_KEY_WORD_0, 32'h0302_0100, 32'h0000_0000, 1'b0, '0},
        '{ROW_KEY,   REG_KEY_WORD_1, 32'h0b0a_0908, 32'h0000_0000, 1'b0, '0},
        '{ROW_KEY,   REG_KEY_WORD_2, 32'h1312_1110, 32'h0000_0000, 1'b0, '0},
        '{ROW_KEY,   REG_KEY_WORD_3, 32'h1b1a_1918, 32'h0000_0000, 1'b0, '0},
        '{ROW_PLAIN, REG_KEY_WORD_0, 32'h3b72_6574, 32'h7475_432d, 1'b1,
          '{32'h8c6f_a548, 32'h454e_028b}},
        '{ROW_PLAIN, REG_KEY_WORD_0, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        // the highest key word alone changed: it must still reach the schedule
        '{ROW_KEY,   REG_KEY_WORD_3, 32'h8000_0000, 32'h0000_0000, 1'b0, '0},
        '{ROW_PLAIN, REG_KEY_WORD_0, 32'h3b72_6574, 32'h7475_432d, 1'b0, '0},
        // lowest key word, i.e. round key 0, down to a single bit
        '{ROW_KEY,   REG_KEY_WORD_0, 32'h0000_0001, 32'h0000_0000, 1'b0, '0},
        '{ROW_PLAIN, REG_KEY_WORD_0, 32'h0000_0001, 32'h8000_0000, 1'b0, '0}
    };

    // Block inputs start at known values; afterwards they are driven by NBA at posedge.
    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    cfg_valid    = 1'b0;
    logic                    cfg_ready;
    logic [REG_IDX_BITS-1:0] cfg_index    = '0;
    logic [FIELD_BITS-1:0]   cfg_data     = '0;
    logic                    in_valid     = 1'b0;
    logic                    in_stall;
    logic [FIELD_BITS-1:0]   plain_left   = '0;
    logic [FIELD_BITS-1:0]   plain_right  = '0;
    logic                    out_valid;
    logic                    out_stall    = 1'b0;
    logic [FIELD_BITS-1:0]   cipher_left;
    logic [FIELD_BITS-1:0]   cipher_right;

    // Sideband travelling with the plaintext word, driven alongside it so that the
    // scoreboard sees it on the same edge as the payload.
    logic   tag_known = 1'b0;
    block_t tag_want  = '0;

    // Shadow of the key registers and the schedule derived from them.
    word_t key_shadow [REG_COUNT];
    word_t round_keys [ROUND_COUNT];

    block_t      cipher_q [$];      // ciphertext words still owed by the block
    int          words_sent    = 0;
    int          words_done    = 0;
    int          mismatches    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          hold_requests = 0;  // bumped by the stimulus, served by the receiver
    int          hold_served   = 0;
    int          quiet_cycles  = 0;

    speck_block_encrypt DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .plain_left   (plain_left),
        .plain_right  (plain_right),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cipher_left  (cipher_left),
        .cipher_right (cipher_right)
    );

    always #(CLK_PERIOD_NS / 2) clk = ~clk;

    // ---------------------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------------------
    function automatic word_t rotr(input word_t v, input int amount);
        return (v >> amount) | (v << (WORD_BITS - amount));
    endfunction

    function automatic word_t rotl(input word_t v, input int amount);
        return (v << amount) | (v >> (WORD_BITS - amount));
    endfunction

    // Standard Speck schedule: key word 0 is round key 0, words 1.. feed the l sequence,
    // which is extended by one word per round.
    function automatic void expand_round_keys();
        word_t sched [ROUND_COUNT + KEY_WORD_COUNT];
        word_t next_l;
        for (int i = 0; i < ROUND_COUNT + KEY_WORD_COUNT; i++)
            sched[i] = '0;
        for (int i = 0; i < KEY_WORD_COUNT - 1; i++)
            sched[i] = key_shadow[i + 1];
        round_keys[0] = key_shadow[0];
        for (int i = 0; i < ROUND_COUNT - 1; i++)
        begin
            next_l = (round_keys[i] + rotr(sched[i], ROT_RIGHT)) ^ word_t'(i);
            sched[i + KEY_WORD_COUNT - 1] = next_l;
            round_keys[i + 1] = rotl(round_keys[i], ROT_LEFT) ^ next_l;
        end
    endfunction

    function automatic block_t speck_encrypt(input word_t left, input word_t right);
        word_t x;
        word_t y;
        x = left;
        y = right;
        for (int i = 0; i < ROUND_COUNT; i++)
        begin
            x = (rotr(x, ROT_RIGHT) + y) ^ round_keys[i];
            y = rotl(y, ROT_LEFT) ^ x;
        end
        return '{x, y};
    endfunction

    // Mostly uniform words, with zero, all ones and single bits mixed in.
    function automatic word_t pick_word();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            2:       return word_t'(1) << $urandom_range(WORD_BITS - 1);
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        $display("mismatch at %0t ns: %s: got %h, want %h", $time, what, got, want);
        mismatches++;
    endtask

    // ---------------------------------------------------------------------------------
    // Driving tasks
    // ---------------------------------------------------------------------------------

    // Offer one plaintext word, after a random gap, and hold it until taken. valid is
    // left high on return so that back-to-back words never drop it in between.
    task automatic send_plain(input word_t left, input word_t right, input logic known,
                              input block_t want);
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        plain_left  <= left;
        plain_right <= right;
        tag_known   <= known;
        tag_want    <= want;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    // Key writes happen only with the pipeline empty, so the shadow schedule can be
    // rebuilt at once; the block itself holds in_stall high while it rebuilds.
    task automatic write_key(input speck_reg_t idx, input word_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        key_shadow[idx] = value;
        expand_round_keys();
    endtask

    // Stop offering and wait until every accepted word has come back out.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (words_done != words_sent)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------------------------
    // Receiver: random stalls, or a long hold-off on request while the sender keeps going
    // ---------------------------------------------------------------------------------
    initial
    begin : receiver
        forever
        begin
            if (hold_served != hold_requests)
            begin
                hold_served++;
                repeat (LONG_HOLD)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
                @(posedge clk);
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Scoreboard: outputs first, so a word leaving and one entering on the same edge
    // are handled in order.
    // ---------------------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        block_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (cipher_q.size() == 0)
                    report_mismatch("cipher word with none pending", cipher_left, '0);
                else
                begin
                    want = cipher_q.pop_front();
                    if (cipher_left !== want.left)
                        report_mismatch("cipher_left", cipher_left, want.left);
                    if (cipher_right !== want.right)
                        report_mismatch("cipher_right", cipher_right, want.right);
                end
                words_done++;
            end
            if (in_valid && !in_stall)
                cipher_q.push_back(tag_known ? tag_want
                                             : speck_encrypt(plain_left, plain_right));
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk)
    begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------------------
    initial
    begin : stimulus
        for (int r = 0; r < REG_COUNT; r++)
            key_shadow[r] = '0;
        expand_round_keys();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table; the first word simply waits out the post-reset key rebuild.
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (DIRECTED[i].kind == ROW_KEY)
            begin
                wait_idle();
                write_key(DIRECTED[i].reg_idx, DIRECTED[i].a);
            end
            else
                send_plain(DIRECTED[i].a, DIRECTED[i].b, DIRECTED[i].known,
                           DIRECTED[i].want);
        end

        // Random phases, each with a fresh key (all zero in one of them).
        for (int p = 0; p < 4; p++)
        begin
            wait_idle();
            send_idle_pct  = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            for (int r = 0; r < REG_COUNT; r++)
                write_key(speck_reg_t'(r), (p == 1) ? word_t'(0) : pick_word());
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // with no idling the long hold fills the pipeline and backs up the input
                if (p == 0 && n == 20)
                    hold_requests++;
                send_plain(pick_word(), pick_word(), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (cipher_q.size() != 0)
            report_mismatch("cipher words never delivered", word_t'(cipher_q.size()), '0);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/speck_pkg.sv
rtl/core/speck_key_sched.sv
rtl/core/speck_round.sv
rtl/core/speck_block_encrypt.sv
tb/speck_block_encrypt_tb.sv
